// File: design/nat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nat_pkg: shared types and constants of the node address table
// Table geometry, operation and status codes, sequencer states and the
// structures that pass between the table modules.
// ----------------------------------------------------------------------------
package nat_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 6;
  localparam int NODE_W      = 8;
  localparam int ADDR_W      = 16;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;

  // Operation codes carried by an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_UPSERT = 2'd0,
    OP_FWD    = 2'd1,
    OP_REV    = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // Status codes reported in a result beat.
  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED     = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_REJECT_ZERO = 3'd2,
    ST_FULL        = 3'd3,
    ST_MISS        = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } seq_state_t;

  // One stored table entry.
  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [ADDR_W-1:0] address;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result beat as handed from the sequencer to the output register.
  typedef struct packed {
    status_t           status;
    logic              hit;
    logic [NODE_W-1:0] node_id_out;
    logic [ADDR_W-1:0] address_out;
    logic [CNT_W-1:0]  entry_count;
  } result_t;

endpackage : nat_pkg
`default_nettype wire

// File: design/nat_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nat_ram: generic single write, single read memory
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module nat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : nat_ram
`default_nettype wire

// File: design/nat_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nat_seq: scan sequencer of the node address table
// Walks the stored entries one read a cycle through a single comparator,
// records the first match, writes back an upsert and forms the result beat.
// ----------------------------------------------------------------------------
module nat_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Request side
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [nat_pkg::OP_W-1:0]     op,
  input  wire logic [nat_pkg::NODE_W-1:0]   node_id,
  input  wire logic [nat_pkg::ADDR_W-1:0]   mesh_address,
  // Table memory
  output logic [nat_pkg::IDX_W-1:0]         rd_addr,
  input  wire nat_pkg::entry_t              rd_data,
  output logic                              wr_en,
  output logic [nat_pkg::IDX_W-1:0]         wr_addr,
  output nat_pkg::entry_t                   wr_data,
  // Result side
  input  wire logic                         res_ready,
  output logic                              res_valid,
  output nat_pkg::result_t                  res
);

  import nat_pkg::*;

  seq_state_t        state, state_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic              found, found_next;
  logic [IDX_W-1:0]  found_idx, found_idx_next;
  entry_t            found_data, found_data_next;
  op_t               op_q;
  logic [NODE_W-1:0] node_q;
  logic [ADDR_W-1:0] addr_q;
  logic              match;
  logic              key_zero;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      found <= found_next;
    end
  end

  // Scan position, match record and the latched request.
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    pend_idx   <= pend_idx_next;
    found_idx  <= found_idx_next;
    found_data <= found_data_next;
    if (state == S_IDLE && in_valid) begin
      op_q   <= op_t'(op);
      node_q <= node_id;
      addr_q <= mesh_address;
    end
  end

  // The one shared comparator: reverse lookups key on the address,
  // everything else keys on the node id.
  always_comb begin
    if (op_q == OP_REV) begin
      match = pend && (rd_data.address == addr_q);
    end else begin
      match = pend && (rd_data.node_id == node_q);
    end
  end

  assign key_zero = (node_q == '0) || (addr_q == '0);
  assign rd_addr  = idx[IDX_W-1:0];

  // Next state, write-back and result.
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    found_next      = found;
    found_idx_next  = found_idx;
    found_data_next = found_data;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = found_idx;
    wr_data.node_id = node_q;
    wr_data.address = addr_q;
    res.status      = ST_MISS;
    res.hit         = 1'b0;
    res.node_id_out = '0;
    res.address_out = '0;
    res.entry_count = count;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          idx_next   = '0;
          pend_next  = 1'b0;
          found_next = 1'b0;
          state_next = S_SCAN;
        end
      end

      S_SCAN: begin
        if (match) begin
          // First matching entry ends the scan.
          found_next      = 1'b1;
          found_idx_next  = pend_idx;
          found_data_next = rd_data;
          pend_next       = 1'b0;
          state_next      = S_FINISH;
        end else if (idx < count) begin
          // Issue the next read; its registered data is compared in the following cycle.
          pend_next     = 1'b1;
          pend_idx_next = idx[IDX_W-1:0];
          idx_next      = idx + CNT_W'(1);
        end else if (!pend) begin
          state_next = S_FINISH;
        end else begin
          // Last read is being compared; nothing further to issue.
          pend_next = 1'b0;
        end
      end

      S_FINISH: begin
        case (op_q)
          OP_UPSERT: begin
            if (key_zero) begin
              res.status = ST_REJECT_ZERO;
            end else if (found) begin
              res.status = ST_UPDATED;
              res.hit    = 1'b1;
              wr_en      = 1'b1;
              wr_addr    = found_idx;
            end else if (count == CNT_W'(TABLE_DEPTH)) begin
              res.status = ST_FULL;
            end else begin
              res.status = ST_INSERTED;
              res.hit    = 1'b1;
              wr_en      = 1'b1;
              wr_addr    = count[IDX_W-1:0];
              res.entry_count = count + CNT_W'(1);
            end
          end
          OP_FWD: begin
            if (found) begin
              res.status      = ST_UPDATED;
              res.hit         = 1'b1;
              res.address_out = found_data.address;
            end
          end
          OP_REV: begin
            if (found) begin
              res.status      = ST_UPDATED;
              res.hit         = 1'b1;
              res.node_id_out = found_data.node_id;
            end
          end
          default: begin
            res.status = ST_MISS;
          end
        endcase

        // Commit only once the output register can take the beat.
        if (res_ready) begin
          res_valid  = 1'b1;
          count_next = res.entry_count;
          state_next = S_IDLE;
        end else begin
          wr_en = 1'b0;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule : nat_seq
`default_nettype wire

// File: design/nat_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nat_out: result output register
// Holds one result beat until the consumer takes it and tells the
// sequencer when the slot can accept the next one.
// ----------------------------------------------------------------------------
module nat_out (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire nat_pkg::result_t              res,
  output logic                               slot_free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [nat_pkg::STATUS_W-1:0]       status,
  output logic                               hit,
  output logic [nat_pkg::NODE_W-1:0]         node_id_out,
  output logic [nat_pkg::ADDR_W-1:0]         address_out,
  output logic [nat_pkg::CNT_W-1:0]          entry_count
);

  import nat_pkg::*;

  result_t data;

  assign slot_free = !out_valid || out_ready;

  // Valid flag of the held beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the held beat.
  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign status      = data.status;
  assign hit         = data.hit;
  assign node_id_out = data.node_id_out;
  assign address_out = data.address_out;
  assign entry_count = data.entry_count;

endmodule : nat_out
`default_nettype wire

// File: design/node_address_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// node_address_table: node id to mesh address table
// Maps 8-bit node ids to 16-bit mesh addresses with upsert, forward lookup
// and reverse lookup, searching the stored entries one at a time.
//
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   op, node_id, mesh_address
//   output   out_valid / out_ready status, hit, node_id_out, address_out,
//                                  entry_count
//
// After acceptance the scan reads one entry a cycle from the table memory
// through a single comparator until a match ends it early or every stored
// entry has been compared; the final step then forms the result. The
// sequencer passes through idle between items, so a new item is accepted
// only after the previous one has left the scan and its final step.
// in_ready is high only while the sequencer is idle. The result register lets
// the next item be accepted while the previous result still waits; a stalled
// output holds the sequencer in its final step until the register frees.
// Reset clears the entry count and control state; the table memory needs no
// clearing pass, as only entries below the count are ever compared.
// ----------------------------------------------------------------------------
module node_address_table (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [nat_pkg::OP_W-1:0]    op,
  input  wire logic [nat_pkg::NODE_W-1:0]  node_id,
  input  wire logic [nat_pkg::ADDR_W-1:0]  mesh_address,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [nat_pkg::STATUS_W-1:0]     status,
  output logic                             hit,
  output logic [nat_pkg::NODE_W-1:0]       node_id_out,
  output logic [nat_pkg::ADDR_W-1:0]       address_out,
  output logic [nat_pkg::CNT_W-1:0]        entry_count
);

  import nat_pkg::*;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;
  entry_t           rd_data;
  entry_t           wr_data;
  logic             slot_free;
  logic             res_valid;
  result_t          res;

  // Table storage.
  nat_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Scan sequencer with the shared comparator.
  nat_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .node_id     (node_id),
    .mesh_address(mesh_address),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .res_ready   (slot_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register.
  nat_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (res_valid),
    .res        (res),
    .slot_free  (slot_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .hit        (hit),
    .node_id_out(node_id_out),
    .address_out(address_out),
    .entry_count(entry_count)
  );

endmodule : node_address_table
`default_nettype wire

// File: design/nat_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nat_chk: port checker of the node address table
// Watches the top-level ports and checks result consistency over time.
// ----------------------------------------------------------------------------
module nat_chk (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [nat_pkg::STATUS_W-1:0] status,
  input wire logic                        hit,
  input wire logic [nat_pkg::NODE_W-1:0]  node_id_out,
  input wire logic [nat_pkg::ADDR_W-1:0]  address_out,
  input wire logic [nat_pkg::CNT_W-1:0]   entry_count
);

  import nat_pkg::*;

  // A held result beat keeps its status and entry count until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("result beat changed while stalled");

  // The table works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // hit agrees with the status code.
  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit == ((status == ST_UPDATED) || (status == ST_INSERTED))))
    else $error("hit disagrees with status");

  // A missed or rejected request returns no data.
  a_nodata: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> (node_id_out == '0) && (address_out == '0))
    else $error("data returned without a hit");

  // An insert leaves at least one entry and never exceeds the table.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INSERTED) |->
      (entry_count != '0) && (entry_count <= CNT_W'(TABLE_DEPTH)))
    else $error("entry count out of range after insert");

endmodule : nat_chk

bind node_address_table nat_chk u_nat_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .hit        (hit),
  .node_id_out(node_id_out),
  .address_out(address_out),
  .entry_count(entry_count)
);
`default_nettype wire
